/* rtl/midi_byte_stream_parser_unit_defines.svh */
// Assertion macros for the MIDI byte stream parser unit.
// Depends on nothing; files that check their own logic include it.
`ifndef MIDI_BYTE_STREAM_PARSER_UNIT_DEFINES_SVH
`define MIDI_BYTE_STREAM_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define MBSP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mbsp check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define MBSP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mbsp check failed");

`endif

/* rtl/mbsp_pkg.sv */
// Shared types and helpers for the MIDI byte stream parser unit.
// Depends on nothing; every module of the unit imports it.
package mbsp_pkg;

	// Message length class of the running status.
	typedef enum logic [1:0] {
		RT_UNDEF = 2'd0,
		RT_ONE   = 2'd1,
		RT_TWO   = 2'd2,
		RT_SYS   = 2'd3
	} run_type_t;

	localparam logic [3:0] KIND_NOTE_OFF  = 4'h8;
	localparam logic [3:0] KIND_NOTE_ON   = 4'h9;
	localparam logic [3:0] KIND_POLY_AT   = 4'hA;
	localparam logic [3:0] KIND_CTRL      = 4'hB;
	localparam logic [3:0] KIND_PROGRAM   = 4'hC;
	localparam logic [3:0] KIND_CHAN_AT   = 4'hD;
	localparam logic [3:0] KIND_PITCH     = 4'hE;
	localparam logic [3:0] KIND_SYSTEM    = 4'hF;

	// Real-time bytes are 0xF8 and above: top five bits all set.
	localparam logic [4:0] REALTIME_PREFIX = 5'h1F;

	// One result item as it leaves the unit.
	typedef struct packed {
		logic       echo_valid;
		logic [7:0] echo_byte;
		logic       cmd_valid;
		logic [3:0] cmd_kind;
		logic [3:0] cmd_channel;
		logic [6:0] cmd_data1;
		logic [6:0] cmd_data2;
	} result_t;

	// Handshake state between the input register and the result register.
	typedef struct packed {
		logic valid_s1;
		logic advance;
	} stage_ctrl_t;

	function automatic run_type_t kind_type(input logic [3:0] kind);
		run_type_t t;
		unique case (kind)
			KIND_NOTE_OFF, KIND_NOTE_ON, KIND_POLY_AT, KIND_CTRL, KIND_PITCH: t = RT_TWO;
			KIND_PROGRAM, KIND_CHAN_AT: t = RT_ONE;
			KIND_SYSTEM: t = RT_SYS;
			default: t = RT_UNDEF;
		endcase
		return t;
	endfunction

endpackage

/* rtl/mbsp_in_stage.sv */
// Input register of the MIDI byte stream parser unit.
// Depends on mbsp_pkg.
module mbsp_in_stage
	import mbsp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic in_xfer;

	// The slot frees up in the same cycle its byte moves on.
	assign in_ready = !valid_s1 || advance;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

/* rtl/mbsp_parser.sv */
// Running status parser: holds the status context and the thru setting
// and forms one result per byte. Depends on mbsp_pkg.
module mbsp_parser
	import mbsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_wdata,
	input  stage_ctrl_t ctrl,
	input  logic [7:0]  byte_s1,
	output result_t     result
);

	logic       thru_q;
	logic [3:0] run_kind_q, run_kind_d;
	run_type_t  run_type_q, run_type_d;
	logic [3:0] run_channel_q, run_channel_d;
	logic [6:0] held_data1_q, held_data1_d;
	logic       second_pending_q, second_pending_d;
	logic       is_realtime;

	assign is_realtime = (byte_s1[7:3] == REALTIME_PREFIX);

	// Next context.
	always_comb begin
		run_kind_d       = run_kind_q;
		run_type_d       = run_type_q;
		run_channel_d    = run_channel_q;
		held_data1_d     = held_data1_q;
		second_pending_d = second_pending_q;
		if (!is_realtime) begin
			if (byte_s1[7]) begin
				run_kind_d       = byte_s1[7:4];
				run_channel_d    = byte_s1[3:0];
				run_type_d       = kind_type(byte_s1[7:4]);
				held_data1_d     = '0;
				second_pending_d = 1'b0;
			end else begin
				unique case (run_type_q)
					RT_ONE: held_data1_d = byte_s1[6:0];
					RT_TWO: begin
						if (second_pending_q) begin
							second_pending_d = 1'b0;
						end else begin
							held_data1_d     = byte_s1[6:0];
							second_pending_d = 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Result for the byte in the input register.
	always_comb begin
		result            = '0;
		result.echo_byte  = byte_s1;
		result.echo_valid = is_realtime || thru_q;
		if (!is_realtime && !byte_s1[7]) begin
			unique case (run_type_q)
				RT_ONE: begin
					result.cmd_valid   = 1'b1;
					result.cmd_kind    = run_kind_q;
					result.cmd_channel = run_channel_q;
					result.cmd_data1   = byte_s1[6:0];
				end
				RT_TWO: begin
					if (second_pending_q) begin
						result.cmd_valid   = 1'b1;
						result.cmd_kind    = run_kind_q;
						result.cmd_channel = run_channel_q;
						result.cmd_data1   = held_data1_q;
						result.cmd_data2   = byte_s1[6:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thru_q           <= 1'b1;
			run_kind_q       <= '0;
			run_type_q       <= RT_UNDEF;
			run_channel_q    <= '0;
			held_data1_q     <= '0;
			second_pending_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				thru_q <= cfg_wdata;
			end
			if (ctrl.advance) begin
				run_kind_q       <= run_kind_d;
				run_type_q       <= run_type_d;
				run_channel_q    <= run_channel_d;
				held_data1_q     <= held_data1_d;
				second_pending_q <= second_pending_d;
			end
		end
	end

endmodule

/* rtl/mbsp_out_stage.sv */
// Result register of the MIDI byte stream parser unit; decides when the
// input register may move on. Depends on mbsp_pkg.
module mbsp_out_stage
	import mbsp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid_s1,
	input  result_t result,
	output logic    advance,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t res_s2
);

	// Move when the result slot is empty or being emptied this cycle.
	assign advance = valid_s1 && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= advance || (out_valid && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

endmodule

/* rtl/midi_byte_stream_parser_unit.sv */
// Top level of the MIDI byte stream parser unit.
// Depends on mbsp_pkg, mbsp_in_stage, mbsp_parser, mbsp_out_stage and the
// assertion macros in midi_byte_stream_parser_unit_defines.svh.
//
// This unit takes one received MIDI byte per transfer on the input channel and
// returns exactly one result per byte on the output channel. Every result
// carries an echo flag and the byte itself for MIDI thru: real-time bytes
// (0xF8 and above) are always flagged for echo, all others only while
// thru_enable is set (reset value 1, written through cfg_wen and cfg_wdata;
// the user must write it only while the unit is idle, a rule the unit leaves
// unchecked). Status bytes set the running status (kind, channel, message
// length) and drop any half-received message; data bytes complete messages
// under running status, one data byte for kinds C and D, two for kinds 8, 9,
// A, B and E. A completed message raises cmd_valid with kind, channel and
// data; otherwise the command fields read zero. Data bytes after a system
// status or before any status produce no command. A byte is held in the input
// register and then moves into the result register, from which its result is
// offered. With the output side ready the unit takes one byte every cycle.
// While a finished result waits in the result register, one more byte can be
// taken into the input register; it is parsed in the cycle the waiting result
// transfers. The running status context advances only when a byte moves from
// the input register into the result register. Reset is asynchronous and
// active low.
`include "midi_byte_stream_parser_unit_defines.svh"

module midi_byte_stream_parser_unit
	import mbsp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// Configuration: thru_enable.
	input  logic       cfg_wen,
	input  logic       cfg_wdata,
	// Input channel.
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	// Output channel.
	output logic       out_valid,
	input  logic       out_ready,
	output logic       echo_valid,
	output logic [7:0] echo_byte,
	output logic       cmd_valid,
	output logic [3:0] cmd_kind,
	output logic [3:0] cmd_channel,
	output logic [6:0] cmd_data1,
	output logic [6:0] cmd_data2
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	stage_ctrl_t ctrl;
	result_t     result;
	result_t     res_s2;
	logic        cmd_fields_clear;

	assign ctrl.valid_s1 = valid_s1;
	assign ctrl.advance  = advance;

	// Input register: holds the byte of the last accepted transfer.
	mbsp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// Parser: running status context and the result for the held byte.
	mbsp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.ctrl      (ctrl),
		.byte_s1   (byte_s1),
		.result    (result)
	);

	// Result register: parts the output handshake from the parser.
	mbsp_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.result    (result),
		.advance   (advance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_s2    (res_s2)
	);

	assign echo_valid  = res_s2.echo_valid;
	assign echo_byte   = res_s2.echo_byte;
	assign cmd_valid   = res_s2.cmd_valid;
	assign cmd_kind    = res_s2.cmd_kind;
	assign cmd_channel = res_s2.cmd_channel;
	assign cmd_data1   = res_s2.cmd_data1;
	assign cmd_data2   = res_s2.cmd_data2;

	assign cmd_fields_clear = (cmd_kind == 4'h0) && (cmd_channel == 4'h0) &&
		(cmd_data1 == 7'h00) && (cmd_data2 == 7'h00);

	// A command only ever carries a channel message kind, 8 to E.
	`MBSP_ASSERT_NOW(a_cmd_kind_channel, out_valid && cmd_valid, cmd_kind[3] && (cmd_kind != KIND_SYSTEM))

	// Without a command the command fields are cleared.
	`MBSP_ASSERT_NOW(a_no_cmd_zero, out_valid && !cmd_valid, cmd_fields_clear)

	// A real-time byte is always echoed and never completes a message.
	`MBSP_ASSERT_NOW(a_realtime_echo, out_valid && (echo_byte[7:3] == REALTIME_PREFIX), echo_valid && !cmd_valid)

	// A byte that moves on is in the result register in the next cycle.
	`MBSP_ASSERT_NEXT(a_advance_lands, advance, out_valid)

endmodule
